// ===== rtl/mad_pkg.sv =====
package mad_pkg;

   localparam int SAMPLE_W = 16;
   localparam int MUL_W    = 18;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int UPC_W    = 4;

   typedef logic [UPC_W-1:0] step_type;

   // program steps
   localparam step_type STEP_IDLE    = 4'd0;
   localparam step_type STEP_GAIN_FB = 4'd1;
   localparam step_type STEP_STORE   = 4'd2;
   localparam step_type STEP_SUB_MOD = 4'd3;
   localparam step_type STEP_SUB_DLY = 4'd4;
   localparam step_type STEP_SPLIT   = 4'd5;
   localparam step_type STEP_WRAP    = 4'd6;
   localparam step_type STEP_RD_IDX  = 4'd7;
   localparam step_type STEP_RD_NXT  = 4'd8;
   localparam step_type STEP_TAKE_B  = 4'd9;
   localparam step_type STEP_INTERP  = 4'd10;
   localparam step_type STEP_OUT     = 4'd11;

   typedef enum logic [2:0] {
      MS_LAST_G, MS_MOD_SPAN, MS_DLY_DEPTH, MS_X_G, MS_DIFF_FRAC
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD_WP, ACC_SUB_P, ACC_SUB_P8
   } acc_op_type;

   typedef enum logic [1:0] {
      IP_HOLD, IP_LOAD, IP_WRAP
   } ip_op_type;

   typedef enum logic [1:0] {
      RAM_NONE, RAM_WRITE, RAM_READ_IDX, RAM_READ_NXT
   } ram_op_type;

   typedef enum logic [1:0] {
      LAT_NONE, LAT_A, LAT_B, LAT_GAIN
   } lat_type;

   // jump to target while the condition holds
   typedef enum logic [1:0] {
      C_NEVER, C_NO_REQ, C_OUT_RANGE, C_RSP_BUSY
   } cond_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      ip_op_type   ip_op;
      ram_op_type  ram_op;
      lat_type     lat;
      cond_type    cond;
      step_type    target;
      logic        fin;
   } ucw_type;

   typedef struct packed {
      ucw_type ucw;
      logic    accept;
      logic    emit;
   } dp_ctl_type;

   typedef struct packed {
      logic out_range;
   } dp_sts_type;

   localparam ucw_type UCW_NOP = '{
      mul_sel: MS_LAST_G, acc_op: ACC_HOLD, ip_op: IP_HOLD, ram_op: RAM_NONE,
      lat: LAT_NONE, cond: C_NEVER, target: STEP_IDLE, fin: 1'b0};

   function automatic ucw_type ucode(input step_type step);
      ucw_type w;
      w = UCW_NOP;
      unique case (step)
         STEP_IDLE: begin
            w.cond   = C_NO_REQ;
            w.target = STEP_IDLE;
         end
         STEP_GAIN_FB: begin
            w.mul_sel = MS_LAST_G;
            w.acc_op  = ACC_LOAD_WP;
         end
         STEP_STORE: begin
            w.ram_op  = RAM_WRITE;
            w.mul_sel = MS_MOD_SPAN;
         end
         STEP_SUB_MOD: begin
            w.acc_op  = ACC_SUB_P;
            w.mul_sel = MS_DLY_DEPTH;
         end
         STEP_SUB_DLY: w.acc_op = ACC_SUB_P8;
         STEP_SPLIT:   w.ip_op  = IP_LOAD;
         STEP_WRAP: begin
            w.ip_op  = IP_WRAP;
            w.cond   = C_OUT_RANGE;
            w.target = STEP_WRAP;
         end
         STEP_RD_IDX: w.ram_op = RAM_READ_IDX;
         STEP_RD_NXT: begin
            w.ram_op = RAM_READ_NXT;
            w.lat    = LAT_A;
         end
         STEP_TAKE_B: begin
            w.lat     = LAT_B;
            w.mul_sel = MS_X_G;
         end
         STEP_INTERP: begin
            w.lat     = LAT_GAIN;
            w.mul_sel = MS_DIFF_FRAC;
         end
         STEP_OUT: begin
            // keep the interpolation product while the result waits
            w.mul_sel = MS_DIFF_FRAC;
            w.cond    = C_RSP_BUSY;
            w.target  = STEP_OUT;
            w.fin     = 1'b1;
         end
         default: begin
            w.cond   = C_NO_REQ;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/modulated_allpass_delay.sv =====
// The sequencer takes an input only in its idle step and finishes that item before it takes the next one;
// it waits in its output step while a previous result waits. Read-index wrap corrections number 0 or 1 for a
// store of 128 entries or more, up to 128/STORE_DEPTH rounded up for smaller stores.
// The single shared 18x18 multiplier and the one read port of the store set the step count.
// Reset (synchronous, active high) returns the sequencer to idle, clears the write pointer and
// the feedback sample; the store reads as zero wherever it has not yet been written.
module modulated_allpass_delay #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // in_sample[15:0], loop_gain[31:16], delay_frac[47:32], mod_offset[63:48]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_sample[15:0]
   output logic [15:0] rsp_tdata
);
   import mad_pkg::*;

   step_type   upc_ff, upc_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   ucw_type    ucw;
   dp_ctl_type ctl;
   dp_sts_type sts;
   logic       req_accept, rsp_busy, jump;
   logic signed [15:0] out_sample;

   assign ucw        = ucode(upc_ff);
   assign req_tready = (upc_ff == STEP_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_busy   = rsp_tvalid_ff && !rsp_tready;

   always_comb begin
      unique case (ucw.cond)
         C_NEVER:     jump = 1'b0;
         C_NO_REQ:    jump = !req_accept;
         C_OUT_RANGE: jump = sts.out_range;
         C_RSP_BUSY:  jump = rsp_busy;
         default:     jump = 1'b0;
      endcase
   end

   always_comb begin
      priority if (jump) begin
         upc_in = ucw.target;
      end else if (ucw.fin) begin
         upc_in = STEP_IDLE;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   assign ctl.ucw    = ucw;
   assign ctl.accept = req_accept;
   assign ctl.emit   = ucw.fin && !jump;

   // hold the result until its transfer
   assign rsp_tvalid_in = ctl.emit || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff        <= STEP_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         upc_ff        <= upc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   mad_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .in_sample  (signed'(req_tdata[15:0])),
      .loop_gain  (req_tdata[31:16]),
      .delay_frac (req_tdata[47:32]),
      .mod_offset (signed'(req_tdata[63:48])),
      .sts        (sts),
      .out_sample (out_sample)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = out_sample;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> upc_ff == STEP_GAIN_FB)
      else $error("sequencer did not start after an input transfer");

   a_index_wrapped: assert property (@(posedge clock) disable iff (reset)
      upc_ff == STEP_RD_IDX |-> !sts.out_range)
      else $error("read index outside the store");

   a_result_from_program: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(upc_ff) == STEP_OUT)
      else $error("result raised outside the output step");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (upc_ff == STEP_IDLE) && !rsp_tvalid_ff)
      else $error("reset did not return to idle");

endmodule

// ===== rtl/mad_ram.sv =====
module mad_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/mad_datapath.sv =====
module mad_datapath #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mad_pkg::dp_ctl_type    ctl,
   input  logic signed [15:0]     in_sample,
   input  logic        [15:0]     loop_gain,
   input  logic        [15:0]     delay_frac,
   input  logic signed [15:0]     mod_offset,
   output mad_pkg::dp_sts_type    sts,
   output logic signed [15:0]     out_sample
);
   import mad_pkg::*;

   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int POS_W = (AW + 24 > 31) ? AW + 24 : 31;
   localparam int ACC_W = POS_W + 2;
   localparam int IP_W  = ACC_W - 24;
   localparam logic        [AW-1:0]    LAST_ADDR = AW'(STORE_DEPTH - 1);
   localparam logic signed [IP_W-1:0]  DEPTH_IP  = IP_W'(STORE_DEPTH);
   localparam logic signed [MUL_W-1:0] DEPTH_M1  = MUL_W'(STORE_DEPTH - 1);

   // captured item
   logic signed [SAMPLE_W-1:0] x_ff, mo_ff;
   logic        [SAMPLE_W-1:0] g_ff, d_ff;

   logic [AW-1:0] wp_ff, wp_in;
   logic          wrapped_ff, wrapped_in;
   logic signed [SAMPLE_W-1:0] last_ff, last_in;

   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [IP_W-1:0]     ip_ff, ip_in;
   logic        [15:0]         frac_ff;
   logic signed [SAMPLE_W-1:0] a_ff, b_ff;
   logic signed [17:0]         gy_ff;
   logic                       rd_ok_ff;

   logic signed [MUL_W-1:0]    op_a, op_b;
   logic        [16:0]         span;
   logic signed [16:0]         diff;
   logic signed [PROD_W-1:0]   gain_sum, interp_sum;
   logic signed [17:0]         gq, ri;
   logic signed [SAMPLE_W-1:0] wr_val, rd_val, rd_data;
   logic signed [18:0]         delayed;
   logic signed [19:0]         y_sum;
   logic [AW-1:0]              idx, nxt, rd_addr;
   logic                       rd_en, wr_en, entry_ok;

   assign span = 17'h10000 - {1'b0, d_ff};
   assign diff = 17'(b_ff) - 17'(a_ff);

   always_comb begin
      unique case (ctl.ucw.mul_sel)
         MS_LAST_G: begin
            op_a = MUL_W'(last_ff);
            op_b = signed'({2'b00, g_ff});
         end
         MS_MOD_SPAN: begin
            op_a = MUL_W'(mo_ff);
            op_b = signed'({1'b0, span});
         end
         MS_DLY_DEPTH: begin
            op_a = signed'({2'b00, d_ff});
            op_b = DEPTH_M1;
         end
         MS_X_G: begin
            op_a = MUL_W'(x_ff);
            op_b = signed'({2'b00, g_ff});
         end
         MS_DIFF_FRAC: begin
            op_a = MUL_W'(diff);
            op_b = signed'({2'b00, frac_ff});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Q1.15 gain product, rounded half up
   assign gain_sum   = prod_ff + 36'sd16384;
   assign gq         = signed'(gain_sum[32:15]);
   assign wr_val     = sat16(20'(x_ff) - 20'(gq));

   // interpolation step, rounded half up
   assign interp_sum = prod_ff + 36'sd32768;
   assign ri         = signed'(interp_sum[33:16]);
   assign delayed    = 19'(a_ff) + 19'(ri);
   assign y_sum      = 20'(gy_ff) + 20'(delayed);

   assign sts.out_range = ip_ff[IP_W-1] || (ip_ff >= DEPTH_IP);

   always_comb begin
      unique case (ctl.ucw.acc_op)
         ACC_HOLD:    acc_in = acc_ff;
         ACC_LOAD_WP: acc_in = signed'({{(ACC_W-AW-24){1'b0}}, wp_ff, 24'd0});
         ACC_SUB_P:   acc_in = acc_ff - ACC_W'(prod_ff);
         ACC_SUB_P8:  acc_in = acc_ff - (ACC_W'(prod_ff) <<< 8);
         default:     acc_in = acc_ff;
      endcase
   end

   always_comb begin
      ip_in = ip_ff;
      unique case (ctl.ucw.ip_op)
         IP_HOLD: ip_in = ip_ff;
         IP_LOAD: ip_in = signed'(acc_ff[ACC_W-1:24]);
         IP_WRAP: begin
            if (ip_ff[IP_W-1]) begin
               ip_in = ip_ff + DEPTH_IP;
            end else if (ip_ff >= DEPTH_IP) begin
               ip_in = ip_ff - DEPTH_IP;
            end
         end
         default: ip_in = ip_ff;
      endcase
   end

   assign idx = ip_ff[AW-1:0];
   assign nxt = (idx == LAST_ADDR) ? '0 : idx + 1'b1;

   assign wr_en   = (ctl.ucw.ram_op == RAM_WRITE);
   assign rd_en   = (ctl.ucw.ram_op == RAM_READ_IDX) || (ctl.ucw.ram_op == RAM_READ_NXT);
   assign rd_addr = (ctl.ucw.ram_op == RAM_READ_NXT) ? nxt : idx;

   // entries 1..wp have been written until the pointer first wraps
   assign entry_ok = wrapped_ff || ((rd_addr != '0) && (rd_addr <= wp_ff));
   assign rd_val   = rd_ok_ff ? rd_data : '0;

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (ctl.accept) begin
         if (wp_ff == LAST_ADDR) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   assign last_in = ctl.emit ? sat16(y_sum) : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         last_ff    <= '0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         x_ff  <= in_sample;
         g_ff  <= loop_gain;
         d_ff  <= delay_frac;
         mo_ff <= mod_offset;
      end
      prod_ff <= op_a * op_b;
      acc_ff  <= acc_in;
      ip_ff   <= ip_in;
      if (ctl.ucw.ip_op == IP_LOAD) begin
         frac_ff <= acc_ff[23:8];
      end
      if (rd_en) begin
         rd_ok_ff <= entry_ok;
      end
      unique case (ctl.ucw.lat)
         LAT_NONE: ;
         LAT_A:    a_ff  <= rd_val;
         LAT_B:    b_ff  <= rd_val;
         LAT_GAIN: gy_ff <= gq;
         default:  ;
      endcase
   end

   mad_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_val),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_sample = last_ff;

endmodule

// ===== verif/tb_modulated_allpass_delay.sv =====
module tb_modulated_allpass_delay;
   timeunit 1ns;
   timeprecision 1ps;

   import mad_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic signed [SAMPLE_W-1:0] in_sample;
      logic [SAMPLE_W-1:0]        loop_gain;
      logic [SAMPLE_W-1:0]        delay_frac;
      logic signed [SAMPLE_W-1:0] mod_offset;
   } allpass_in_type;

   class allpass_scoreboard;
      shortint           delay_line [STORE_DEPTH];
      int                wr_ptr;
      shortint           feedback;
      logic [SAMPLE_W-1:0] expected_out [$];
      int                checked;
      int                failures;

      function longint scale_by_gain(longint sample, longint gain);
         return (sample * gain + 16384) >>> 15;
      endfunction

      function shortint clip16(longint v);
         if (v > 32767) begin
            return 16'sh7fff;
         end else if (v < -32768) begin
            return 16'sh8000;
         end
         return shortint'(v);
      endfunction

      // advance the pointer, write, then read back the interpolated tap
      function void note_input(allpass_in_type s);
         longint x, g, d, mo, span, pos, frac, a, b, tap;
         int     idx, nxt;
         x    = s.in_sample;
         g    = s.loop_gain;
         d    = s.delay_frac;
         mo   = s.mod_offset;
         span = longint'(STORE_DEPTH) * 65536;
         wr_ptr = (wr_ptr == STORE_DEPTH - 1) ? 0 : wr_ptr + 1;
         delay_line[wr_ptr] = clip16(x - scale_by_gain(feedback, g));
         // read position in 2^-24 sample units, floored to 2^-16
         pos = longint'(wr_ptr) * 16777216 - mo * (65536 - d)
             - d * longint'(STORE_DEPTH - 1) * 256;
         pos = (pos >>> 8) % span;
         if (pos < 0) begin
            pos += span;
         end
         idx  = int'(pos / 65536);
         frac = pos % 65536;
         nxt  = (idx + 1) % STORE_DEPTH;
         a    = delay_line[idx];
         b    = delay_line[nxt];
         tap  = a + (((b - a) * frac + 32768) >>> 16);
         feedback = clip16(scale_by_gain(x, g) + tap);
         expected_out.push_back(feedback);
      endfunction

      function void check_out_sample(logic [SAMPLE_W-1:0] got);
         logic [SAMPLE_W-1:0] want;
         if (expected_out.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("unexpected output transfer: out_sample=%h", got);
            end
            return;
         end
         want = expected_out.pop_front();
         checked++;
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("out_sample mismatch at output %0d: expected %h, got %h",
                        checked, want, got);
            end
         end
      endfunction

      function int pending();
         return expected_out.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   allpass_scoreboard sb;
   bit idle_on;
   bit hold_request;
   int samples_sent;

   modulated_allpass_delay #(
      .STORE_DEPTH(STORE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic allpass_in_type make_sample(logic [15:0] x, logic [15:0] g,
                                                  logic [15:0] d, logic [15:0] mo);
      allpass_in_type s;
      s.in_sample  = x;
      s.loop_gain  = g;
      s.delay_frac = d;
      s.mod_offset = mo;
      return s;
   endfunction

   // short delays in half the picks so reads land on written taps; the rest full range
   function automatic allpass_in_type random_sample();
      allpass_in_type s;
      int             pick;
      pick = $urandom_range(0, 7);
      s.in_sample = (pick == 0) ? ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000)
                                : 16'($urandom);
      pick = $urandom_range(0, 7);
      if (pick < 4) begin
         s.loop_gain = 16'($urandom_range(0, 32768));
      end else if (pick < 6) begin
         s.loop_gain = 16'($urandom);
      end else begin
         case ($urandom_range(0, 2))
            0:       s.loop_gain = 16'd0;
            1:       s.loop_gain = 16'd32768;
            default: s.loop_gain = 16'hffff;
         endcase
      end
      pick = $urandom_range(0, 7);
      if (pick < 4) begin
         s.delay_frac = 16'($urandom_range(0, 1023));
      end else if (pick < 7) begin
         s.delay_frac = 16'($urandom);
      end else begin
         s.delay_frac = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      end
      pick = $urandom_range(0, 7);
      if (pick < 4) begin
         s.mod_offset = 16'($urandom_range(0, 4095) - 2048);
      end else if (pick < 7) begin
         s.mod_offset = 16'($urandom);
      end else begin
         s.mod_offset = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      return s;
   endfunction

   task automatic offer_sample(input allpass_in_type s);
      req_tvalid <= 1'b1;
      req_tdata  <= {s.mod_offset, s.delay_frac, s.loop_gain, s.in_sample};
      do @(posedge clock); while (!req_tready);
      sb.note_input(s);
      samples_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // output side: random stalls plus one long hold-off on request
   initial begin : output_side
      int stall_left;
      int hold_left;
      bit ready_next;
      stall_left = 0;
      hold_left  = 0;
      wait (sb != null);
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_out_sample(rsp_tdata);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      allpass_in_type directed [$];
      int             n;
      sb = new;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      // zero delay and modulation read the tap just written
      directed.push_back(make_sample(16'd1000, 16'd0, 16'd0, 16'h0000));
      directed.push_back(make_sample(16'h7fff, 16'd32768, 16'd0, 16'h0000));
      directed.push_back(make_sample(16'h8000, 16'd32768, 16'd0, 16'h0000));
      // gain above unity, sums clip
      directed.push_back(make_sample(16'h7fff, 16'hffff, 16'd0, 16'h0000));
      directed.push_back(make_sample(16'h8000, 16'hffff, 16'd0, 16'h0000));
      directed.push_back(make_sample(16'd12345, 16'd16384, 16'hffff, 16'h0000));
      directed.push_back(make_sample(-16'sd20000, 16'd16384, 16'h8000, 16'h0180));
      // large positive modulation pulls the position below zero
      directed.push_back(make_sample(16'd5000, 16'd24576, 16'd0, 16'h7fff));
      // large negative modulation pushes it ahead of the pointer
      directed.push_back(make_sample(-16'sd5000, 16'd24576, 16'd0, 16'h8000));
      directed.push_back(make_sample(16'd0, 16'd0, 16'd0, 16'h0000));
      directed.push_back(make_sample(16'd7000, 16'd32768, 16'd0, 16'h0100));
      directed.push_back(make_sample(16'd7000, 16'd32768, 16'd0, 16'hff00));
      directed.push_back(make_sample(16'hffff, 16'd32768, 16'd1, 16'h0080));
      directed.push_back(make_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
      directed.push_back(make_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
      directed.push_back(make_sample(16'h7fff, 16'hffff, 16'hffff, 16'h7fff));
      directed.push_back(make_sample(16'h8000, 16'd0, 16'hffff, 16'h8000));
      foreach (directed[i]) begin
         offer_sample(directed[i]);
      end

      for (n = 0; n < 1300; n++) begin
         if (n == 400) begin
            hold_request = 1'b1;
         end
         if (n == 800) begin
            // drain everything before going on
            req_tvalid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
         offer_sample(random_sample());
      end

      idle_on = 1'b0;
      for (n = 0; n < 140; n++) begin
         offer_sample(random_sample());
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d samples sent, %0d outputs checked, %0d failures", samples_sent,
               sb.checked, sb.failures + sb.pending());
      $display("covered clipped extremes, gains to 2.0, full delay and modulation wrap,");
      $display("random stalls on both sides, a long output hold-off and a full drain");
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
